>>> design/nlp_pkg.sv
package nlp_pkg;

    // Field widths fixed by the item format.
    localparam int POS_W = 3;
    localparam int LEN_W = 4;
    localparam int CMD_W = 1;

    // Register reset value.
    localparam logic [LEN_W-1:0] LEN_RESET = 4'd8;

    // Item kinds carried on s_tuser.
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 1'b0,
        CMD_ADVANCE = 1'b1
    } cmd_t;

endpackage

>>> design/next_lexicographic_permutation_top.sv
// Next lexicographic permutation engine.
//
// The input channel (s_*) carries two kinds of beat, chosen by s_tuser. A load
// beat writes one key into the key memory at a position and gives no result.
// An advance beat steps the first length_in_use keys to their next
// lexicographic permutation and then sends every key in use on the result
// channel (m_*), position 0 first, with tlast on the final beat and tuser
// saying whether a next permutation existed. If none did, the keys stay put.
// The user writes length_in_use through cfg_wr_en / cfg_wr_data only while idle; the block does not enforce it.
//
// The key memory has a single read port, so keys are visited one at a time
// in the scan, the search, the suffix reversal and the output phase. One
// item is processed at a time.
//
// aresetn (synchronous, active low) returns the controller to idle, empties
// the output register and sets length_in_use to 8; key memory is not cleared.
// A stalled receiver holds the output beat and pauses the output phase.
module next_lexicographic_permutation_top
    import nlp_pkg::*;
#(
    parameter int MAX_ELEMENTS = 8,
    parameter int KEY_BITS     = 64
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // Configuration: length_in_use.
    input  logic                    cfg_wr_en,
    input  logic [LEN_W-1:0]        cfg_wr_data,
    // Input channel.
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // tdata, lowest bit up: position, key, zero padding.
    input  logic [((POS_W+KEY_BITS+7)/8)*8-1:0] s_tdata,
    // tuser: command.
    input  logic [CMD_W-1:0]        s_tuser,
    // Result channel.
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // tdata, lowest bit up: out_position, out_key, zero padding.
    output logic [((POS_W+KEY_BITS+7)/8)*8-1:0] m_tdata,
    // tuser: has_next.
    output logic [0:0]              m_tuser,
    output logic                    m_tlast
);

    localparam int TDATA_W = ((POS_W + KEY_BITS + 7) / 8) * 8;
    localparam int IDX_W   = $clog2(MAX_ELEMENTS);
    localparam int PAD_W   = TDATA_W - POS_W - KEY_BITS;

    localparam logic [3:0] ST_IDLE       = 4'd0;
    localparam logic [3:0] ST_SCAN_FIRST = 4'd1;
    localparam logic [3:0] ST_SCAN       = 4'd2;
    localparam logic [3:0] ST_FIND       = 4'd3;
    localparam logic [3:0] ST_SWAP       = 4'd4;
    localparam logic [3:0] ST_REV_LO     = 4'd5;
    localparam logic [3:0] ST_REV_HI     = 4'd6;
    localparam logic [3:0] ST_REV_WL     = 4'd7;
    localparam logic [3:0] ST_REV_WH     = 4'd8;
    localparam logic [3:0] ST_EMIT       = 4'd9;

    logic [POS_W-1:0]    in_position;
    logic [KEY_BITS-1:0] in_key;
    cmd_t                in_cmd;

    assign in_position = s_tdata[POS_W-1:0];
    assign in_key      = s_tdata[POS_W +: KEY_BITS];
    assign in_cmd      = cmd_t'(s_tuser);

    // Key memory.
    logic [KEY_BITS-1:0] key_mem [MAX_ELEMENTS];
    logic                mem_wr_en;
    logic [IDX_W-1:0]    mem_wr_addr;
    logic [KEY_BITS-1:0] mem_wr_data;
    logic                mem_rd_en;
    logic [IDX_W-1:0]    mem_rd_addr;
    logic [KEY_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            key_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            rd_data_reg <= key_mem[mem_rd_addr];
        end
    end

    // Control registers.
    logic [LEN_W-1:0]    len_reg;
    logic [3:0]          state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    lastidx_reg, lastidx_next;
    logic [IDX_W-1:0]    p_reg, p_next;
    logic [IDX_W-1:0]    j_reg, j_next;
    logic [IDX_W-1:0]    lo_reg, lo_next;
    logic [IDX_W-1:0]    hi_reg, hi_next;
    logic                has_reg, has_next;
    logic [KEY_BITS-1:0] prev_reg, prev_next;
    logic [KEY_BITS-1:0] pkey_reg, pkey_next;
    logic [KEY_BITS-1:0] tmp_reg, tmp_next;

    // Output register.
    logic                m_valid_reg;
    logic [POS_W-1:0]    m_pos_reg;
    logic [KEY_BITS-1:0] m_key_reg;
    logic                m_has_reg;
    logic                m_last_reg;
    logic                out_load;
    logic                emit_last;

    // Number of keys in use, less one, after clamping the register to 1..MAX.
    logic [IDX_W-1:0]    act_last;

    always_comb begin
        if (len_reg == '0) begin
            act_last = '0;
        end else if (32'(len_reg) > 32'(MAX_ELEMENTS)) begin
            act_last = IDX_W'(MAX_ELEMENTS - 1);
        end else begin
            act_last = IDX_W'(len_reg - LEN_W'(1));
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign emit_last = (idx_reg == lastidx_reg);

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        lastidx_next = lastidx_reg;
        p_next       = p_reg;
        j_next       = j_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        has_next     = has_reg;
        prev_next    = prev_reg;
        pkey_next    = pkey_reg;
        tmp_next     = tmp_reg;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = '0;
        mem_wr_data  = '0;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = '0;
        out_load     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (in_cmd == CMD_LOAD) begin
                        if (32'(in_position) < 32'(MAX_ELEMENTS)) begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = IDX_W'(in_position);
                            mem_wr_data = in_key;
                        end
                    end else begin
                        lastidx_next = act_last;
                        mem_rd_en    = 1'b1;
                        if (act_last == '0) begin
                            // A single key has no successor.
                            has_next    = 1'b0;
                            mem_rd_addr = '0;
                            idx_next    = '0;
                            state_next  = ST_EMIT;
                        end else begin
                            mem_rd_addr = act_last;
                            idx_next    = act_last;
                            state_next  = ST_SCAN_FIRST;
                        end
                    end
                end
            end
            ST_SCAN_FIRST: begin
                prev_next   = rd_data_reg;
                mem_rd_en   = 1'b1;
                mem_rd_addr = idx_reg - IDX_W'(1);
                idx_next    = idx_reg - IDX_W'(1);
                state_next  = ST_SCAN;
            end
            ST_SCAN: begin
                mem_rd_en = 1'b1;
                if (prev_reg > rd_data_reg) begin
                    // Pivot found; look from the right for the first larger key.
                    has_next    = 1'b1;
                    p_next      = idx_reg;
                    pkey_next   = rd_data_reg;
                    j_next      = lastidx_reg;
                    mem_rd_addr = lastidx_reg;
                    state_next  = ST_FIND;
                end else if (idx_reg == '0) begin
                    has_next    = 1'b0;
                    mem_rd_addr = '0;
                    idx_next    = '0;
                    state_next  = ST_EMIT;
                end else begin
                    prev_next   = rd_data_reg;
                    mem_rd_addr = idx_reg - IDX_W'(1);
                    idx_next    = idx_reg - IDX_W'(1);
                end
            end
            ST_FIND: begin
                // The suffix is non-increasing, so the first larger key from
                // the right is the smallest larger one.
                if (rd_data_reg > pkey_reg) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = p_reg;
                    mem_wr_data = rd_data_reg;
                    state_next  = ST_SWAP;
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = j_reg - IDX_W'(1);
                    j_next      = j_reg - IDX_W'(1);
                end
            end
            ST_SWAP: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = j_reg;
                mem_wr_data = pkey_reg;
                lo_next     = p_reg + IDX_W'(1);
                hi_next     = lastidx_reg;
                state_next  = ST_REV_LO;
            end
            ST_REV_LO: begin
                // Reversing the still non-increasing suffix sorts it ascending.
                mem_rd_en = 1'b1;
                if (lo_reg < hi_reg) begin
                    mem_rd_addr = lo_reg;
                    state_next  = ST_REV_HI;
                end else begin
                    mem_rd_addr = '0;
                    idx_next    = '0;
                    state_next  = ST_EMIT;
                end
            end
            ST_REV_HI: begin
                tmp_next    = rd_data_reg;
                mem_rd_en   = 1'b1;
                mem_rd_addr = hi_reg;
                state_next  = ST_REV_WL;
            end
            ST_REV_WL: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = lo_reg;
                mem_wr_data = rd_data_reg;
                state_next  = ST_REV_WH;
            end
            ST_REV_WH: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = hi_reg;
                mem_wr_data = tmp_reg;
                lo_next     = lo_reg + IDX_W'(1);
                hi_next     = hi_reg - IDX_W'(1);
                state_next  = ST_REV_LO;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    out_load = 1'b1;
                    if (emit_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = idx_reg + IDX_W'(1);
                        idx_next    = idx_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= LEN_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                len_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        lastidx_reg <= lastidx_next;
        p_reg       <= p_next;
        j_reg       <= j_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        has_reg     <= has_next;
        prev_reg    <= prev_next;
        pkey_reg    <= pkey_next;
        tmp_reg     <= tmp_next;
        if (out_load) begin
            m_pos_reg  <= POS_W'(idx_reg);
            m_key_reg  <= rd_data_reg;
            m_has_reg  <= has_reg;
            m_last_reg <= emit_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {PAD_W'(0), m_key_reg, m_pos_reg};
    assign m_tuser  = m_has_reg;
    assign m_tlast  = m_last_reg;

    // The memory is only written by a load or by the swap and reversal steps.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> (state_reg == ST_IDLE || state_reg == ST_FIND ||
                       state_reg == ST_SWAP || state_reg == ST_REV_WL ||
                       state_reg == ST_REV_WH))
        else $error("key memory written outside a write step");

    // The search for a larger key never reaches the pivot.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIND) |-> (j_reg > p_reg))
        else $error("successor search passed the pivot");

    // A pair is only swapped while the reversal pointers have not crossed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REV_HI) |-> (lo_reg < hi_reg))
        else $error("reversal pointers crossed");

    // The final key of a run goes out with tlast and the engine goes idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && emit_last) |=> (m_tvalid && m_tlast && state_reg == ST_IDLE))
        else $error("run did not end with tlast");

    // An output beat is never overwritten before it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !out_load)
        else $error("stalled output beat overwritten");

endmodule
